FILE: hw/rtl/smcc_pkg.sv
// ----------------------------------------------------------------------------
// smcc_pkg
// Shared types, constants and width helper for the servo/motor command block.
// ----------------------------------------------------------------------------
`default_nettype none

package smcc_pkg;

	localparam int unsigned NUM_SERVOS_DEF = 4;
	localparam int unsigned SCALE_SHIFT    = 6;

	localparam int unsigned WIDTH_W  = 15;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned MIN_W    = 14;

	localparam logic [PERIOD_W-1:0] PERIOD_TOP_RST = 16'd40000;
	localparam logic [MIN_W-1:0]    MIN_PULSE_RST  = 14'd4800;
	localparam logic [WIDTH_W-1:0]  WIDTH_SAT      = 15'h7FFF;

	// item kinds
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// first-byte commands
	localparam logic [7:0] CMD_SERVO_OFF  = 8'hFF;
	localparam logic [7:0] CMD_MOTOR_STOP = 8'hFE;

	// two-byte commands
	localparam logic [7:0] CMD_SERVO_LIMIT = 8'd4;
	localparam logic [7:0] CMD_MOTOR1_FWD  = 8'd4;
	localparam logic [7:0] CMD_MOTOR2_FWD  = 8'd5;
	localparam logic [7:0] CMD_MOTOR1_REV  = 8'd6;
	localparam logic [7:0] CMD_MOTOR2_REV  = 8'd7;

	localparam logic [7:0] VALUE_CLAMP = 8'd225;
	localparam logic [7:0] VALUE_OFF   = 8'd255;

	typedef logic [WIDTH_W-1:0] width_t;

	typedef struct packed {
		logic       func;
		logic [7:0] byte_value;
	} item_t;

	typedef struct packed {
		logic [3:0] servo_pins;
		logic [1:0] servo_slot;
		logic [7:0] motor1_duty;
		logic       motor1_forward;
		logic [7:0] motor2_duty;
		logic       motor2_forward;
	} result_t;

	typedef struct packed {
		logic [7:0] duty_one;
		logic       dir_one;
		logic [7:0] duty_two;
		logic       dir_two;
	} motor_t;

	// (value << shift) + min_pulse, saturated to the width range
	function automatic width_t scale_width(input logic [7:0] value,
		input logic [MIN_W-1:0] min_pulse);
		logic [16:0] sum;
		sum = (17'(value) << SCALE_SHIFT) + 17'(min_pulse);
		if (sum > 17'(WIDTH_SAT)) begin
			return WIDTH_SAT;
		end
		return sum[WIDTH_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/smcc_cmd.sv
// ----------------------------------------------------------------------------
// smcc_cmd
// Command byte parser: servo pending widths, motor duty and direction.
// ----------------------------------------------------------------------------
`default_nettype none

module smcc_cmd #(
	parameter int unsigned NUM_SERVOS = smcc_pkg::NUM_SERVOS_DEF
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           fire,
	input  logic                                           is_byte,
	input  logic [7:0]                                     byte_value,
	input  logic [smcc_pkg::MIN_W-1:0]                     min_pulse,
	output logic [NUM_SERVOS-1:0][smcc_pkg::WIDTH_W-1:0]   pending,
	output logic                                           servo_off,
	output smcc_pkg::motor_t                               motor_next
);
	import smcc_pkg::*;

	localparam width_t WIDTH_OFF_RST = scale_width(VALUE_OFF, MIN_PULSE_RST);

	logic                               awaiting_q;
	logic [7:0]                         command_q;
	logic [NUM_SERVOS-1:0][WIDTH_W-1:0] pending_q;
	motor_t                             motor_q;

	logic                               awaiting_next;
	logic [7:0]                         command_next;
	logic [NUM_SERVOS-1:0][WIDTH_W-1:0] pending_next;
	logic [7:0]                         value_clamped;
	width_t                             servo_width;
	width_t                             off_width;

	always_comb begin
		value_clamped = byte_value;
		if (byte_value > VALUE_CLAMP && byte_value < VALUE_OFF) begin
			value_clamped = VALUE_CLAMP;
		end
		servo_width = scale_width(value_clamped, min_pulse);
		off_width   = scale_width(VALUE_OFF, min_pulse);
	end

	always_comb begin
		awaiting_next = awaiting_q;
		command_next  = command_q;
		pending_next  = pending_q;
		motor_next    = motor_q;
		servo_off     = 1'b0;
		if (is_byte) begin
			if (!awaiting_q) begin
				command_next = byte_value;
				if (byte_value == CMD_SERVO_OFF) begin
					servo_off = 1'b1;
					for (int i = 0; i < NUM_SERVOS; i++) begin
						pending_next[i] = off_width;
					end
				end else if (byte_value == CMD_MOTOR_STOP) begin
					motor_next.duty_one = 8'd0;
					motor_next.duty_two = 8'd0;
				end else begin
					awaiting_next = 1'b1;
				end
			end else begin
				awaiting_next = 1'b0;
				if (command_q < CMD_SERVO_LIMIT) begin
					// drop servo commands beyond the fitted servos
					for (int i = 0; i < NUM_SERVOS; i++) begin
						if (command_q == 8'(i)) begin
							pending_next[i] = servo_width;
						end
					end
				end else begin
					case (command_q)
						CMD_MOTOR1_FWD, CMD_MOTOR1_REV: begin
							motor_next.dir_one  = (command_q == CMD_MOTOR1_FWD);
							motor_next.duty_one = byte_value;
						end
						CMD_MOTOR2_FWD, CMD_MOTOR2_REV: begin
							motor_next.dir_two  = (command_q == CMD_MOTOR2_FWD);
							motor_next.duty_two = byte_value;
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			command_q  <= 8'd0;
			motor_q    <= '0;
			for (int i = 0; i < NUM_SERVOS; i++) begin
				pending_q[i] <= WIDTH_OFF_RST;
			end
		end else if (fire) begin
			awaiting_q <= awaiting_next;
			command_q  <= command_next;
			pending_q  <= pending_next;
			motor_q    <= motor_next;
		end
	end

	assign pending = pending_q;

endmodule

`default_nettype wire

FILE: hw/rtl/smcc_timer.sv
// ----------------------------------------------------------------------------
// smcc_timer
// Slot period counter: loads the slot width at the wrap, drops the pin at
// the match and steps to the next servo.
// ----------------------------------------------------------------------------
`default_nettype none

module smcc_timer #(
	parameter int unsigned NUM_SERVOS = smcc_pkg::NUM_SERVOS_DEF,
	parameter int unsigned SLOT_W     = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           fire,
	input  logic                                           is_tick,
	input  logic                                           servo_off,
	input  logic [NUM_SERVOS-1:0][smcc_pkg::WIDTH_W-1:0]   pending,
	input  logic [smcc_pkg::PERIOD_W-1:0]                  period_top,
	input  logic [smcc_pkg::MIN_W-1:0]                     min_pulse,
	output logic [NUM_SERVOS-1:0]                          pins_next,
	output logic [SLOT_W-1:0]                              slot_next
);
	import smcc_pkg::*;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SERVOS - 1);

	logic [PERIOD_W-1:0]   tick_q;
	width_t                match_q;
	width_t                active_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [NUM_SERVOS-1:0] pins_q;

	logic [PERIOD_W-1:0]   tick_next;
	width_t                match_next;
	width_t                active_next;
	width_t                bound;
	logic                  enabled;

	always_comb begin
		bound       = scale_width(VALUE_CLAMP, min_pulse);
		tick_next   = tick_q;
		match_next  = match_q;
		active_next = active_q;
		slot_next   = slot_q;
		pins_next   = pins_q;
		if (is_tick) begin
			if (tick_q == period_top) begin
				tick_next   = '0;
				active_next = pending[slot_q];
				match_next  = pending[slot_q];
			end else begin
				tick_next = tick_q + PERIOD_W'(1);
			end
		end
		enabled = (active_next <= bound);
		if (is_tick) begin
			if (tick_q == period_top && enabled) begin
				pins_next[slot_q] = 1'b1;
			end
			if (tick_next == PERIOD_W'(match_next)) begin
				if (enabled) begin
					pins_next[slot_q] = 1'b0;
				end
				slot_next = (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
			end
		end
		// drop every pin, leave the running period alone
		if (servo_off) begin
			pins_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			match_q  <= '0;
			active_q <= '0;
			slot_q   <= '0;
			pins_q   <= '0;
		end else if (fire) begin
			tick_q   <= tick_next;
			match_q  <= match_next;
			active_q <= active_next;
			slot_q   <= slot_next;
			pins_q   <= pins_next;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/servo_motor_command_controller_unit.sv
// ----------------------------------------------------------------------------
// servo_motor_command_controller_unit
// Flow: input register, then result register. Throughput: one word per cycle
// while results drain; input register, single-pass update and result register
// overlap, so a word enters an empty input register while a result waits.
// Reset: servos disabled, motors stopped, timer and slot at zero,
// period_top 40000, min_pulse 4800.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_motor_command_controller_unit #(
	parameter int unsigned NUM_SERVOS = smcc_pkg::NUM_SERVOS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  smcc_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output smcc_pkg::result_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import smcc_pkg::*;

	localparam int unsigned SLOT_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
	localparam int unsigned PIN_X  = (NUM_SERVOS > 4) ? NUM_SERVOS : 4;
	localparam int unsigned SLOT_X = (SLOT_W > 2) ? SLOT_W : 2;

	localparam logic REG_PERIOD_TOP = 1'b0;
	localparam logic REG_MIN_PULSE  = 1'b1;

	logic [PERIOD_W-1:0] period_top_q;
	logic [MIN_W-1:0]    min_pulse_q;

	logic    valid_s1;
	item_t   item_s1;
	logic    result_valid_q;
	result_t result_q;
	logic    advance;

	logic [NUM_SERVOS-1:0][WIDTH_W-1:0] pending;
	logic                               servo_off;
	motor_t                             motor_next;
	logic [NUM_SERVOS-1:0]              pins_next;
	logic [SLOT_W-1:0]                  slot_next;
	logic [PIN_X-1:0]                   pins_x;
	logic [SLOT_X-1:0]                  slot_x;

	// configuration port; byte lanes below the word address are ignored
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_top_q <= PERIOD_TOP_RST;
			min_pulse_q  <= MIN_PULSE_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_PERIOD_TOP: period_top_q <= pwdata[PERIOD_W-1:0];
				REG_MIN_PULSE:  min_pulse_q  <= pwdata[MIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_PERIOD_TOP: prdata = 32'(period_top_q);
			REG_MIN_PULSE:  prdata = 32'(min_pulse_q);
			default:        prdata = '0;
		endcase
	end

	// word flow: input register, then result register
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	smcc_cmd #(
		.NUM_SERVOS(NUM_SERVOS)
	) u_cmd (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.is_byte    (item_s1.func == FUNC_BYTE),
		.byte_value (item_s1.byte_value),
		.min_pulse  (min_pulse_q),
		.pending    (pending),
		.servo_off  (servo_off),
		.motor_next (motor_next)
	);

	smcc_timer #(
		.NUM_SERVOS(NUM_SERVOS),
		.SLOT_W    (SLOT_W)
	) u_timer (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.is_tick    (item_s1.func == FUNC_TICK),
		.servo_off  (servo_off),
		.pending    (pending),
		.period_top (period_top_q),
		.min_pulse  (min_pulse_q),
		.pins_next  (pins_next),
		.slot_next  (slot_next)
	);

	assign pins_x = PIN_X'(pins_next);
	assign slot_x = SLOT_X'(slot_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.servo_pins     <= pins_x[3:0];
			result_q.servo_slot     <= slot_x[1:0];
			result_q.motor1_duty    <= motor_next.duty_one;
			result_q.motor1_forward <= motor_next.dir_one;
			result_q.motor2_duty    <= motor_next.duty_two;
			result_q.motor2_forward <= motor_next.dir_two;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire
